/* hdl/lrf_pkg.sv */
// lrf_pkg: shared types, constants and crc32c helpers of the log record fragmenter
// no dependencies; used by lrf_front, lrf_queue, lrf_back and log_record_fragmenter_top
`timescale 1ns / 1ps

package lrf_pkg;

    // block size is a power of two, 2**6 .. 2**16 bytes
    localparam int BLOCK_LOG2  = 15;
    localparam int BLOCK_SIZE  = 2 ** BLOCK_LOG2;
    localparam int OFF_W       = BLOCK_LOG2 + 1;
    localparam int POS_W       = 48;
    localparam int LEN_W       = 16;
    localparam int CRC_W       = 32;
    localparam int HDR_BYTES   = 7;
    localparam int ADV_W       = 5;
    localparam int TDATA_W     = 112;

    localparam logic [OFF_W-1:0] BLOCK_END = OFF_W'(BLOCK_SIZE);
    localparam logic [OFF_W-1:0] HDR_OFF   = OFF_W'(HDR_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CRC_W-1:0] CRC_POLY       = 32'h82F63B78;
    localparam logic [CRC_W-1:0] CRC_INIT       = 32'hFFFFFFFF;
    localparam logic [CRC_W-1:0] CRC_MASK_DELTA = 32'hA282EAD8;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAD     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        TYPE_NONE   = 3'd0,
        TYPE_FULL   = 3'd1,
        TYPE_FIRST  = 3'd2,
        TYPE_MIDDLE = 3'd3,
        TYPE_LAST   = 3'd4
    } t_frag_type;

    typedef enum logic [1:0] {
        PH_PRE  = 2'd0,
        PH_MID  = 2'd1,
        PH_POST = 2'd2
    } t_phase;

    // one result word; crc holds the raw register, masked on the way out
    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   pos;
        logic [7:0]         data;
        logic [CRC_W-1:0]   crc;
        logic [LEN_W-1:0]   len;
        t_frag_type         ftype;
        logic [2:0]         pad;
    } t_slot;

    // everything one input word causes: optional pad or empty header, the
    // byte or the closing header of an empty record, optional closing header
    typedef struct packed {
        logic   pre_valid;
        t_slot  pre;
        t_slot  mid;
        logic   post_valid;
        t_slot  post;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // reflected crc32c, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] crc_mask(input logic [CRC_W-1:0] crc_in);
        logic [CRC_W-1:0] c;
        c = ~crc_in;
        return {c[14:0], c[31:15]} + CRC_MASK_DELTA;
    endfunction

    // crc registers right after the type byte of each fragment type
    localparam logic [CRC_W-1:0] SEED_FULL   = crc_byte(CRC_INIT, {5'd0, TYPE_FULL});
    localparam logic [CRC_W-1:0] SEED_FIRST  = crc_byte(CRC_INIT, {5'd0, TYPE_FIRST});
    localparam logic [CRC_W-1:0] SEED_MIDDLE = crc_byte(CRC_INIT, {5'd0, TYPE_MIDDLE});
    localparam logic [CRC_W-1:0] SEED_LAST   = crc_byte(CRC_INIT, {5'd0, TYPE_LAST});

endpackage

/* hdl/log_record_fragmenter_top.sv */
// log_record_fragmenter_top: write-ahead-log framing of record bytes with crc32c fragment headers
// depends on lrf_pkg, lrf_front, lrf_queue, lrf_back
//
//   channel   | direction | word contents
//   ----------+-----------+---------------------------------------------------------------
//   s_axis    | in        | tdata: data_byte; tlast: record_end; tuser: empty_record
//   m_axis    | out       | tdata: position, out_byte, header_crc, header_length,
//             |           |        header_type, pad_length; tuser: kind; tlast: run_last
//   cfg       | in        | i_cfg_data: start_length (log file length), always ready
//
// one input word enters per cycle while the queue has room; it yields one to three result
// words, and the output register hands out one result word per cycle while m_axis is
// ready, so a word that closes a fragment or needs tail padding holds the input side
// once the two-entry queue fills. each result word passes the queue, then the output register.
// reset (synchronous, active low) restarts framing at zero; a cfg write at start_length.
// either side may stall on its own; the queue and the output register absorb it.
`timescale 1ns / 1ps

module log_record_fragmenter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lrf_pkg::POS_W-1:0]     i_cfg_data,
    // record bytes in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
    input  logic                          s_axis_tlast,
    input  logic                          s_axis_tuser,   // [0] empty_record
    // layout words out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [47:0] position, [55:48] out_byte, [87:56] header_crc,
    // [103:88] header_length, [106:104] header_type, [109:107] pad_length, rest zero
    output logic [lrf_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,   // [1:0] kind
    output logic                          m_axis_tlast
);

    lrf_pkg::t_entry     w_entry;
    lrf_pkg::t_entry     w_head;
    lrf_pkg::t_q_status  w_q_status;
    logic                w_push;
    logic                w_pop;

    // the user must issue config writes only while idle; the block does not enforce this and always takes them
    assign o_cfg_ready = 1'b1;

    // front: block/fragment bookkeeping and both crc32c registers
    lrf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (s_axis_tvalid),
        .i_data_byte    (s_axis_tdata),
        .i_record_end   (s_axis_tlast),
        .i_empty_record (s_axis_tuser),
        .i_q_status     (w_q_status),
        .o_ready        (s_axis_tready),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    // entries of up to three result words
    lrf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // back: one result word per cycle while the output is ready, crc masking on the way out
    lrf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_user     (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // padding only ever fills a tail shorter than a header
    ap_pad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == lrf_pkg::KIND_PAD) |->
        (m_axis_tdata[109:107] != 3'd0 && m_axis_tdata[109:107] <= 3'd6))
        else $error("pad word with bad length");

    // header words carry a real fragment type and fit in one block
    ap_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == lrf_pkg::KIND_HEADER) |->
        ((m_axis_tdata[106:104] == lrf_pkg::TYPE_FULL ||
          m_axis_tdata[106:104] == lrf_pkg::TYPE_FIRST ||
          m_axis_tdata[106:104] == lrf_pkg::TYPE_MIDDLE ||
          m_axis_tdata[106:104] == lrf_pkg::TYPE_LAST) &&
         (32'(m_axis_tdata[103:88]) <= 32'(lrf_pkg::BLOCK_SIZE - lrf_pkg::HDR_BYTES))))
        else $error("header word with bad type or length");

    // back part never retires an entry the queue does not hold
    ap_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

    // an accepted word is in the queue on the next cycle
    ap_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !w_q_status.empty)
        else $error("accepted word lost");
`endif

endmodule

/* hdl/lrf_front.sv */
// lrf_front: accepts record bytes, tracks block and fragment state, builds one queue entry per word
// depends on lrf_pkg
`timescale 1ns / 1ps

module lrf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [lrf_pkg::POS_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_record_end,
    input  logic                          i_empty_record,
    input  lrf_pkg::t_q_status            i_q_status,
    output logic                          o_ready,
    output logic                          o_push,
    output lrf_pkg::t_entry               o_entry
);

    logic [lrf_pkg::OFF_W-1:0] r_boff,   n_boff;
    logic [lrf_pkg::POS_W-1:0] r_fpos,   n_fpos;
    logic [lrf_pkg::POS_W-1:0] r_hpos,   n_hpos;
    logic [lrf_pkg::LEN_W-1:0] r_flen,   n_flen;
    logic [lrf_pkg::CRC_W-1:0] r_cb,     n_cb;
    logic [lrf_pkg::CRC_W-1:0] r_cc,     n_cc;
    logic                      r_rb,     n_rb;
    logic                      r_in_frag, n_in_frag;

    logic [lrf_pkg::OFF_W-1:0] left, boff_open, boff_b, boff_new;
    logic                      open_frag, short_tail, pad_v, dbl;
    logic [2:0]                skip;
    logic [lrf_pkg::ADV_W-1:0] open_adv, byte_adv;
    logic [lrf_pkg::POS_W-1:0] pos_skip, pos_body, byte_pos, pos_after;
    logic                      rb_cur, close_cont;
    logic [lrf_pkg::CRC_W-1:0] cb_base, cc_base, cb_new, cc_new;
    logic [lrf_pkg::POS_W-1:0] hpos_cur;
    logic [lrf_pkg::LEN_W-1:0] flen_base, flen_new;

    function automatic lrf_pkg::t_slot hdr_slot(input logic [lrf_pkg::POS_W-1:0] pos,
                                                input logic [lrf_pkg::CRC_W-1:0] crc,
                                                input logic [lrf_pkg::LEN_W-1:0] len,
                                                input lrf_pkg::t_frag_type ftype);
        lrf_pkg::t_slot s;
        s       = '0;
        s.kind  = lrf_pkg::KIND_HEADER;
        s.pos   = pos;
        s.crc   = crc;
        s.len   = len;
        s.ftype = ftype;
        return s;
    endfunction

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        // opening a fragment: pad a short tail, then reserve the header
        open_frag  = !r_in_frag;
        left       = lrf_pkg::BLOCK_END - r_boff;
        short_tail = left < lrf_pkg::HDR_OFF;
        skip       = (open_frag && short_tail) ? left[2:0] : 3'd0;
        pad_v      = open_frag && short_tail && (left != '0);
        boff_open  = ((open_frag && short_tail) ? '0 : r_boff) + lrf_pkg::HDR_OFF;
        // exactly a header's room left and a byte to place
        dbl        = !i_empty_record && open_frag && (boff_open == lrf_pkg::BLOCK_END);

        open_adv   = lrf_pkg::ADV_W'(skip) + lrf_pkg::ADV_W'(lrf_pkg::HDR_BYTES);
        byte_adv   = !open_frag ? '0 :
                     (dbl ? lrf_pkg::ADV_W'(2 * lrf_pkg::HDR_BYTES) : open_adv);
        pos_skip   = r_fpos + lrf_pkg::POS_W'(skip);
        pos_body   = r_fpos + lrf_pkg::POS_W'(open_adv);
        byte_pos   = r_fpos + lrf_pkg::POS_W'(byte_adv);
        pos_after  = r_fpos + lrf_pkg::POS_W'(byte_adv + lrf_pkg::ADV_W'(1));

        rb_cur     = dbl ? 1'b0 : r_rb;
        cb_base    = open_frag ? (rb_cur ? lrf_pkg::SEED_FULL  : lrf_pkg::SEED_LAST)   : r_cb;
        cc_base    = open_frag ? (rb_cur ? lrf_pkg::SEED_FIRST : lrf_pkg::SEED_MIDDLE) : r_cc;
        hpos_cur   = open_frag ? (dbl ? pos_body : pos_skip) : r_hpos;
        flen_base  = open_frag ? '0 : r_flen;
        boff_b     = dbl ? lrf_pkg::HDR_OFF : (open_frag ? boff_open : r_boff);

        boff_new   = boff_b + lrf_pkg::OFF_W'(1);
        flen_new   = flen_base + lrf_pkg::LEN_W'(1);
        cb_new     = lrf_pkg::crc_byte(cb_base, i_data_byte);
        cc_new     = lrf_pkg::crc_byte(cc_base, i_data_byte);
        close_cont = !i_record_end && (boff_new == lrf_pkg::BLOCK_END);

        // entry
        o_entry           = '0;
        o_entry.pre_valid = pad_v || dbl;
        if (pad_v) begin
            o_entry.pre.kind = lrf_pkg::KIND_PAD;
            o_entry.pre.pos  = r_fpos;
            o_entry.pre.pad  = left[2:0];
        end else begin
            o_entry.pre = hdr_slot(r_fpos,
                                   r_rb ? lrf_pkg::SEED_FIRST : lrf_pkg::SEED_MIDDLE,
                                   '0,
                                   r_rb ? lrf_pkg::TYPE_FIRST : lrf_pkg::TYPE_MIDDLE);
        end
        if (i_empty_record) begin
            o_entry.mid = hdr_slot(hpos_cur, cb_base, flen_base,
                                   rb_cur ? lrf_pkg::TYPE_FULL : lrf_pkg::TYPE_LAST);
        end else begin
            o_entry.mid.kind = lrf_pkg::KIND_PAYLOAD;
            o_entry.mid.pos  = byte_pos;
            o_entry.mid.data = i_data_byte;
        end
        o_entry.post_valid = !i_empty_record && (i_record_end || close_cont);
        if (i_record_end) begin
            o_entry.post = hdr_slot(hpos_cur, cb_new, flen_new,
                                    rb_cur ? lrf_pkg::TYPE_FULL : lrf_pkg::TYPE_LAST);
        end else begin
            o_entry.post = hdr_slot(hpos_cur, cc_new, flen_new,
                                    rb_cur ? lrf_pkg::TYPE_FIRST : lrf_pkg::TYPE_MIDDLE);
        end

        // next state
        n_boff    = r_boff;
        n_fpos    = r_fpos;
        n_hpos    = r_hpos;
        n_flen    = r_flen;
        n_cb      = r_cb;
        n_cc      = r_cc;
        n_rb      = r_rb;
        n_in_frag = r_in_frag;
        if (i_cfg_valid) begin
            n_boff    = {1'b0, i_cfg_data[lrf_pkg::BLOCK_LOG2-1:0]};
            n_fpos    = i_cfg_data;
            n_hpos    = '0;
            n_flen    = '0;
            n_cb      = '0;
            n_cc      = '0;
            n_rb      = 1'b1;
            n_in_frag = 1'b0;
        end else if (o_push) begin
            if (i_empty_record) begin
                n_boff    = open_frag ? boff_open : r_boff;
                n_fpos    = open_frag ? pos_body : r_fpos;
                n_rb      = 1'b1;
                n_in_frag = 1'b0;
            end else begin
                n_boff    = boff_new;
                n_fpos    = pos_after;
                n_hpos    = hpos_cur;
                n_flen    = flen_new;
                n_cb      = cb_new;
                n_cc      = cc_new;
                n_in_frag = !(i_record_end || close_cont);
                n_rb      = i_record_end ? 1'b1 : (close_cont ? 1'b0 : rb_cur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boff    <= '0;
            r_fpos    <= '0;
            r_rb      <= 1'b1;
            r_in_frag <= 1'b0;
        end else begin
            r_boff    <= n_boff;
            r_fpos    <= n_fpos;
            r_rb      <= n_rb;
            r_in_frag <= n_in_frag;
        end
    end

    // only read while a fragment is open
    always_ff @(posedge i_clk) begin
        r_hpos <= n_hpos;
        r_flen <= n_flen;
        r_cb   <= n_cb;
        r_cc   <= n_cc;
    end

endmodule

/* hdl/lrf_queue.sv */
// lrf_queue: short entry queue between the front and back parts
// depends on lrf_pkg
`timescale 1ns / 1ps

module lrf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lrf_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output lrf_pkg::t_entry     o_head,
    output lrf_pkg::t_q_status  o_status
);

    lrf_pkg::t_entry            r_mem [lrf_pkg::QUEUE_DEPTH];
    logic [lrf_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [lrf_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [lrf_pkg::QCNT_W-1:0] r_cnt, n_cnt;

    function automatic logic [lrf_pkg::QPTR_W-1:0] ptr_inc(
        input logic [lrf_pkg::QPTR_W-1:0] p);
        return (p == lrf_pkg::QPTR_W'(lrf_pkg::QUEUE_DEPTH - 1)) ?
               '0 : p + lrf_pkg::QPTR_W'(1);
    endfunction

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == lrf_pkg::QCNT_W'(lrf_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd  = i_pop  ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt + lrf_pkg::QCNT_W'(i_push) - lrf_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* hdl/lrf_back.sv */
// lrf_back: walks the slots of the head entry and drives the registered result word
// depends on lrf_pkg
`timescale 1ns / 1ps

module lrf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lrf_pkg::t_entry              i_head,
    input  lrf_pkg::t_q_status           i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lrf_pkg::TDATA_W-1:0]  o_data,
    output logic [1:0]                   o_user,
    output logic                         o_last
);

    lrf_pkg::t_phase               r_phase, n_phase, eff;
    logic                          r_valid, n_valid;
    logic [lrf_pkg::TDATA_W-1:0]   r_data;
    logic [1:0]                    r_user;
    logic                          r_last;
    lrf_pkg::t_slot                slot;
    logic                          load, last_slot;
    logic [lrf_pkg::CRC_W-1:0]     crc_out;

    always_comb begin
        eff = (r_phase == lrf_pkg::PH_PRE && !i_head.pre_valid) ? lrf_pkg::PH_MID : r_phase;
        case (eff)
            lrf_pkg::PH_PRE:  slot = i_head.pre;
            lrf_pkg::PH_MID:  slot = i_head.mid;
            lrf_pkg::PH_POST: slot = i_head.post;
            default:          slot = i_head.mid;
        endcase
        last_slot = (eff == lrf_pkg::PH_POST) ||
                    (eff == lrf_pkg::PH_MID && !i_head.post_valid);
        load      = !i_q_status.empty && (!r_valid || i_ready);
        o_pop     = load && last_slot;
        crc_out   = (slot.kind == lrf_pkg::KIND_HEADER) ? lrf_pkg::crc_mask(slot.crc) : '0;

        n_phase = r_phase;
        if (load) begin
            if (last_slot) begin
                n_phase = lrf_pkg::PH_PRE;
            end else begin
                case (eff)
                    lrf_pkg::PH_PRE: n_phase = lrf_pkg::PH_MID;
                    lrf_pkg::PH_MID: n_phase = lrf_pkg::PH_POST;
                    default:         n_phase = lrf_pkg::PH_PRE;
                endcase
            end
        end
        n_valid = load ? 1'b1 : (i_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lrf_pkg::PH_PRE;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= {2'b00, slot.pad, slot.ftype, slot.len, crc_out, slot.data, slot.pos};
            r_user <= slot.kind;
            r_last <= last_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule
